/* rtl/core/ntcbc_pkg.sv */
// Shared types and constants of the NTC beta-equation temperature converter.
`timescale 1ns / 1ps
package ntcbc_pkg;

   localparam int SAMPLE_W  = 12;   // width of one ADC sample field
   localparam int SUM_W     = 17;   // holds up to 32 full-scale samples
   localparam int LOG_X_W   = 41;   // 24-bit register times 17-bit sum
   localparam int EXP_W     = 6;    // exponent of the log operand, 0..40
   localparam int MANT_W    = 32;   // normalised mantissa, 31 fraction bits
   localparam int FRAC_W    = 16;   // fraction bits of log2
   localparam int LOG_W     = EXP_W + FRAC_W;
   localparam int DIV_W     = 54;   // dividend and quotient of the final divide
   localparam int REM_W     = 40;   // divisor width and remainder width
   localparam int STEP_W    = 6;
   localparam int SQ_STEPS  = 16;

   localparam int KELVIN_OFFSET = 27315;
   localparam int LN2_Q16       = 45426;
   localparam int Q_MAX         = 60082;  // largest kelvin value that fits the output

   localparam logic signed [15:0] TEMP_MAX = 16'sd32767;
   localparam logic signed [15:0] TEMP_MIN = -16'sd27315;

   localparam logic [1:0] REG_SERIES  = 2'd0;
   localparam logic [1:0] REG_NOMINAL = 2'd1;
   localparam logic [1:0] REG_BETA    = 2'd2;
   localparam logic [1:0] REG_NTEMP   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RATIO   = 2'd1;
   localparam logic [1:0] STATUS_SHORTED = 2'd2;
   localparam logic [1:0] STATUS_SAT     = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACC,
      OP_PROD,
      OP_LOAD1,
      OP_LOAD2,
      OP_NORM,
      OP_MANT,
      OP_SQ,
      OP_SAVE,
      OP_DIFF,
      OP_LN,
      OP_DEN1,
      OP_DEN2,
      OP_DSAT,
      OP_DIVLD,
      OP_DIV,
      OP_QRES,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic norm_done;
      logic early;
      logic den_bad;
   } dp_status_type;

endpackage

/* rtl/core/ntcbc_datapath.sv */
// Datapath: sample sums, configuration registers, log unit, divider and result registers.
`timescale 1ns / 1ps
module ntcbc_datapath #(
   parameter int ADC_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ntcbc_pkg::op_type             op,
   output ntcbc_pkg::dp_status_type      status,
   input  logic                          csr_wen,
   input  logic [1:0]                    csr_index,
   input  logic [23:0]                   csr_wdata,
   input  logic [ntcbc_pkg::SAMPLE_W-1:0] therm_sample,
   input  logic [ntcbc_pkg::SAMPLE_W-1:0] ref_sample,
   output logic signed [15:0]            temperature,
   output logic [1:0]                    status_code
);

   localparam int SW = ntcbc_pkg::SAMPLE_W;
   localparam logic [SW-1:0] SAMPLE_MASK =
      (ADC_BITS >= SW) ? {SW{1'b1}} : SW'((1 << ADC_BITS) - 1);

   logic [23:0]        series_ff, nominal_ff;
   logic [13:0]        beta_ff;
   logic signed [14:0] ntemp_ff;

   logic [ntcbc_pkg::SUM_W-1:0]   therm_sum_ff, ref_sum_ff;
   logic [ntcbc_pkg::LOG_X_W-1:0] p1_ff, p2_ff, x_ff;
   logic [ntcbc_pkg::EXP_W-1:0]   exp_ff;
   logic [ntcbc_pkg::MANT_W-1:0]  m_ff;
   logic [ntcbc_pkg::FRAC_W-1:0]  frac_ff;
   logic [ntcbc_pkg::LOG_W-1:0]   log1_ff;
   logic signed [ntcbc_pkg::LOG_W:0] diff_ff;
   logic signed [21:0]            lq_ff;
   logic signed [38:0]            a_ff;
   logic [29:0]                   bn_ff;
   logic signed [40:0]            d_ff;
   logic [52:0]                   num_ff;
   logic [ntcbc_pkg::DIV_W-1:0]   dvd_ff;
   logic [ntcbc_pkg::REM_W-1:0]   rem_ff;
   logic signed [15:0]            res_temp_ff;
   logic [1:0]                    res_stat_ff;
   logic                          early_ff;
   logic signed [15:0]            out_temp_ff;
   logic [1:0]                    out_stat_ff;

   logic [ntcbc_pkg::SUM_W-1:0]   sum_gap;
   logic [63:0]                   sq_full;
   logic [32:0]                   sq_scaled;
   logic [ntcbc_pkg::LOG_W-1:0]   diff_mag;
   logic [36:0]                   ln_prod;
   logic [20:0]                   ln_mag;
   logic signed [16:0]            n_kelvin;
   logic [20:0]                   beta_x100;
   logic [36:0]                   bn_x100;
   logic [ntcbc_pkg::REM_W:0]     rem_shift;
   logic                          rem_ge;

   always_comb begin
      sum_gap   = ref_sum_ff - therm_sum_ff;
      sq_full   = 64'(m_ff) * 64'(m_ff);
      sq_scaled = sq_full[63:31];
      diff_mag  = diff_ff[ntcbc_pkg::LOG_W] ? ntcbc_pkg::LOG_W'(-diff_ff)
                                            : ntcbc_pkg::LOG_W'(diff_ff);
      ln_prod   = 37'(diff_mag) * 37'(ntcbc_pkg::LN2_Q16) + 37'd32768;
      ln_mag    = ln_prod[36:16];
      n_kelvin  = 17'(ntemp_ff) + 17'sd27315;
      beta_x100 = 21'(beta_ff) * 21'd100;
      bn_x100   = 37'(bn_ff) * 37'd100;
      rem_shift = {rem_ff, dvd_ff[ntcbc_pkg::DIV_W-1]};
      rem_ge    = rem_shift >= {1'b0, d_ff[ntcbc_pkg::REM_W-1:0]};
   end

   assign status.norm_done = x_ff[ntcbc_pkg::LOG_X_W-1];
   assign status.early     = early_ff;
   assign status.den_bad   = (d_ff <= 41'sd0);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= 24'd100000;
         nominal_ff <= 24'd100000;
         beta_ff    <= 14'd3950;
         ntemp_ff   <= 15'sd2500;
      end else if (csr_wen) begin
         case (csr_index)
            ntcbc_pkg::REG_SERIES:  series_ff  <= csr_wdata;
            ntcbc_pkg::REG_NOMINAL: nominal_ff <= csr_wdata;
            ntcbc_pkg::REG_BETA:    beta_ff    <= csr_wdata[13:0];
            ntcbc_pkg::REG_NTEMP:   ntemp_ff   <= $signed(csr_wdata[14:0]);
            default: ;
         endcase
      end
   end

   // Running sums are state and clear on reset and after each reading.
   always_ff @(posedge clock) begin
      if (reset) begin
         therm_sum_ff <= '0;
         ref_sum_ff   <= '0;
         early_ff     <= 1'b0;
      end else begin
         case (op)
            ntcbc_pkg::OP_ACC: begin
               therm_sum_ff <= therm_sum_ff + ntcbc_pkg::SUM_W'(therm_sample & SAMPLE_MASK);
               ref_sum_ff   <= ref_sum_ff + ntcbc_pkg::SUM_W'(ref_sample & SAMPLE_MASK);
            end
            ntcbc_pkg::OP_OUT: begin
               therm_sum_ff <= '0;
               ref_sum_ff   <= '0;
            end
            ntcbc_pkg::OP_PROD: early_ff <= (ref_sum_ff <= therm_sum_ff) ||
                                            (therm_sum_ff == '0) || (series_ff == '0) ||
                                            (nominal_ff == '0);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         ntcbc_pkg::OP_PROD: begin
            p1_ff <= ntcbc_pkg::LOG_X_W'(series_ff) * ntcbc_pkg::LOG_X_W'(therm_sum_ff);
            p2_ff <= ntcbc_pkg::LOG_X_W'(sum_gap) * ntcbc_pkg::LOG_X_W'(nominal_ff);
            if (ref_sum_ff <= therm_sum_ff) begin
               res_temp_ff <= 16'sd0;
               res_stat_ff <= ntcbc_pkg::STATUS_RATIO;
            end else if ((therm_sum_ff == '0) || (series_ff == '0)) begin
               res_temp_ff <= ntcbc_pkg::TEMP_MIN;
               res_stat_ff <= ntcbc_pkg::STATUS_SHORTED;
            end else begin
               res_temp_ff <= ntcbc_pkg::TEMP_MIN;
               res_stat_ff <= ntcbc_pkg::STATUS_SAT;
            end
         end
         ntcbc_pkg::OP_LOAD1: begin
            x_ff   <= p1_ff;
            exp_ff <= ntcbc_pkg::EXP_W'(ntcbc_pkg::LOG_X_W - 1);
         end
         ntcbc_pkg::OP_LOAD2: begin
            x_ff   <= p2_ff;
            exp_ff <= ntcbc_pkg::EXP_W'(ntcbc_pkg::LOG_X_W - 1);
         end
         ntcbc_pkg::OP_NORM: begin
            x_ff   <= {x_ff[ntcbc_pkg::LOG_X_W-2:0], 1'b0};
            exp_ff <= exp_ff - 1'b1;
         end
         ntcbc_pkg::OP_MANT: begin
            m_ff    <= x_ff[ntcbc_pkg::LOG_X_W-1 -: ntcbc_pkg::MANT_W];
            frac_ff <= '0;
         end
         ntcbc_pkg::OP_SQ: begin
            // Squaring doubles the log; a carry into bit 32 is the next fraction bit.
            if (sq_scaled[32]) begin
               m_ff    <= sq_scaled[32:1];
               frac_ff <= {frac_ff[ntcbc_pkg::FRAC_W-2:0], 1'b1};
            end else begin
               m_ff    <= sq_scaled[31:0];
               frac_ff <= {frac_ff[ntcbc_pkg::FRAC_W-2:0], 1'b0};
            end
         end
         ntcbc_pkg::OP_SAVE: log1_ff <= {exp_ff, frac_ff};
         ntcbc_pkg::OP_DIFF: diff_ff <= $signed({1'b0, log1_ff}) -
                                        $signed({1'b0, exp_ff, frac_ff});
         ntcbc_pkg::OP_LN:
            lq_ff <= diff_ff[ntcbc_pkg::LOG_W] ? -$signed({1'b0, ln_mag})
                                               : $signed({1'b0, ln_mag});
         ntcbc_pkg::OP_DEN1: begin
            a_ff  <= 39'(lq_ff) * 39'(n_kelvin);
            bn_ff <= 30'(beta_ff) * 30'(n_kelvin[15:0]);
         end
         ntcbc_pkg::OP_DEN2: begin
            d_ff   <= 41'(a_ff) + $signed({4'b0, beta_x100, 16'b0});
            num_ff <= {bn_x100[36:0], 16'b0};
         end
         ntcbc_pkg::OP_DSAT: begin
            res_temp_ff <= ntcbc_pkg::TEMP_MAX;
            res_stat_ff <= ntcbc_pkg::STATUS_SAT;
         end
         ntcbc_pkg::OP_DIVLD: begin
            // Adding half the divisor rounds the quotient half up.
            dvd_ff <= ntcbc_pkg::DIV_W'(num_ff) +
                      ntcbc_pkg::DIV_W'(d_ff[ntcbc_pkg::REM_W-1:1]);
            rem_ff <= '0;
         end
         ntcbc_pkg::OP_DIV: begin
            rem_ff <= rem_ge ? ntcbc_pkg::REM_W'(rem_shift -
                                                 {1'b0, d_ff[ntcbc_pkg::REM_W-1:0]})
                             : rem_shift[ntcbc_pkg::REM_W-1:0];
            dvd_ff <= {dvd_ff[ntcbc_pkg::DIV_W-2:0], rem_ge};
         end
         ntcbc_pkg::OP_QRES: begin
            if (dvd_ff > ntcbc_pkg::DIV_W'(ntcbc_pkg::Q_MAX)) begin
               res_temp_ff <= ntcbc_pkg::TEMP_MAX;
               res_stat_ff <= ntcbc_pkg::STATUS_SAT;
            end else begin
               res_temp_ff <= $signed(dvd_ff[15:0] - 16'(ntcbc_pkg::KELVIN_OFFSET));
               res_stat_ff <= ntcbc_pkg::STATUS_OK;
            end
         end
         ntcbc_pkg::OP_OUT: begin
            out_temp_ff <= res_temp_ff;
            out_stat_ff <= res_stat_ff;
         end
         default: ;
      endcase
   end

   assign temperature = out_temp_ff;
   assign status_code = out_stat_ff;

endmodule

/* rtl/core/ntcbc_ctrl.sv */
// Controller: sequences accumulation, the two logarithms, the divide and the result hand-off.
`timescale 1ns / 1ps
module ntcbc_ctrl #(
   parameter int SAMPLES_PER_READING = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  ntcbc_pkg::dp_status_type status,
   output ntcbc_pkg::op_type        op
);

   localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_PROD, S_CHK, S_LOAD1, S_NORM1, S_SQ1, S_SAVE, S_LOAD2, S_NORM2,
      S_SQ2, S_DIFF, S_LN, S_DEN1, S_DEN2, S_DCHK, S_DIV, S_QRES, S_OUT
   } state_type;

   state_type                        state_ff;
   logic [CNT_W-1:0]                 pair_count_ff;
   logic [ntcbc_pkg::STEP_W-1:0]     step_ff;
   logic                             rsp_valid_ff;
   logic                             slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      case (state_ff)
         S_IDLE:  op = (req_tvalid) ? ntcbc_pkg::OP_ACC : ntcbc_pkg::OP_NONE;
         S_PROD:  op = ntcbc_pkg::OP_PROD;
         S_LOAD1: op = ntcbc_pkg::OP_LOAD1;
         S_LOAD2: op = ntcbc_pkg::OP_LOAD2;
         S_NORM1, S_NORM2:
            op = status.norm_done ? ntcbc_pkg::OP_MANT : ntcbc_pkg::OP_NORM;
         S_SQ1, S_SQ2: op = ntcbc_pkg::OP_SQ;
         S_SAVE:  op = ntcbc_pkg::OP_SAVE;
         S_DIFF:  op = ntcbc_pkg::OP_DIFF;
         S_LN:    op = ntcbc_pkg::OP_LN;
         S_DEN1:  op = ntcbc_pkg::OP_DEN1;
         S_DEN2:  op = ntcbc_pkg::OP_DEN2;
         S_DCHK:  op = status.den_bad ? ntcbc_pkg::OP_DSAT : ntcbc_pkg::OP_DIVLD;
         S_DIV:   op = ntcbc_pkg::OP_DIV;
         S_QRES:  op = ntcbc_pkg::OP_QRES;
         S_OUT:   op = slot_free ? ntcbc_pkg::OP_OUT : ntcbc_pkg::OP_NONE;
         default: op = ntcbc_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pair_count_ff <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if ((state_ff == S_OUT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  if (pair_count_ff == CNT_W'(SAMPLES_PER_READING - 1)) begin
                     pair_count_ff <= '0;
                     state_ff      <= S_PROD;
                  end else begin
                     pair_count_ff <= pair_count_ff + 1'b1;
                  end
               end
            end
            S_PROD: state_ff <= S_CHK;
            S_CHK:  state_ff <= status.early ? S_OUT : S_LOAD1;
            S_LOAD1: state_ff <= S_NORM1;
            S_NORM1: begin
               step_ff <= '0;
               if (status.norm_done) begin
                  state_ff <= S_SQ1;
               end
            end
            S_SQ1: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == ntcbc_pkg::STEP_W'(ntcbc_pkg::SQ_STEPS - 1)) begin
                  state_ff <= S_SAVE;
               end
            end
            S_SAVE:  state_ff <= S_LOAD2;
            S_LOAD2: state_ff <= S_NORM2;
            S_NORM2: begin
               step_ff <= '0;
               if (status.norm_done) begin
                  state_ff <= S_SQ2;
               end
            end
            S_SQ2: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == ntcbc_pkg::STEP_W'(ntcbc_pkg::SQ_STEPS - 1)) begin
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF: state_ff <= S_LN;
            S_LN:   state_ff <= S_DEN1;
            S_DEN1: state_ff <= S_DEN2;
            S_DEN2: state_ff <= S_DCHK;
            S_DCHK: begin
               step_ff  <= '0;
               state_ff <= status.den_bad ? S_OUT : S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == ntcbc_pkg::STEP_W'(ntcbc_pkg::DIV_W - 1)) begin
                  state_ff <= S_QRES;
               end
            end
            S_QRES: state_ff <= S_OUT;
            S_OUT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* rtl/core/ntc_beta_temperature_converter.sv */
// Top level of the NTC thermistor temperature converter (beta equation).
//
// Usage: sample pairs arrive on the req_ channel, one request per pair
// (thermistor node and reference node ADC readings). Each request that is
// taken is added to two running sums. The request that completes a
// set of SAMPLES_PER_READING pairs starts the reading: the resistance ratio
// goes through two logarithms (normalisation and repeated squaring each,
// one shared log unit) and a bit-serial divide of a 54-bit dividend. The
// delay from the last pair of a set to its reading depends on the log
// normalisation. When the denominator is not positive the divide is
// skipped. Requests are taken only while the controller is idle.
// Readings that hit a special case (bad ratio, shorted sensor, zero nominal
// resistance) skip the logarithms and the divide.
// The reading is held in an output register on the rsp_ channel with a
// status code. While it waits, the next set is accepted; only a reading
// that finishes while the previous one is still held waits for rsp_tready.
// Reset is synchronous: it clears the sums, the pair count and rsp_tvalid
// and restores the configuration registers to their defaults. csr_ writes
// are taken in the cycle of csr_wen and must only happen while idle.
`timescale 1ns / 1ps
module ntc_beta_temperature_converter #(
   parameter int SAMPLES_PER_READING = 20,
   parameter int ADC_BITS            = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // therm_sample [11:0], ref_sample [23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // temperature [15:0], status [17:16], zero pad
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   ntcbc_pkg::op_type        op;
   ntcbc_pkg::dp_status_type dp_status;
   logic signed [15:0]       temperature;
   logic [1:0]               status_code;

   ntcbc_ctrl #(
      .SAMPLES_PER_READING(SAMPLES_PER_READING)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .op         (op)
   );

   ntcbc_datapath #(
      .ADC_BITS(ADC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .status       (dp_status),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .therm_sample (req_tdata[11:0]),
      .ref_sample   (req_tdata[23:12]),
      .temperature  (temperature),
      .status_code  (status_code)
   );

   assign rsp_tdata = {6'b0, status_code, temperature};

endmodule

/* rtl/core/ntcbc_checker.sv */
// Port-level checks of the converter, bound to the top level.
`timescale 1ns / 1ps
module ntcbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // No reading is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("reading offered straight after reset");

   // A stalled reading holds its value.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled reading changed");

   // A bad ratio always reports zero temperature.
   a_ratio_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[17:16] == ntcbc_pkg::STATUS_RATIO)
      |-> (rsp_tdata[15:0] == 16'd0))
      else $error("bad-ratio reading with non-zero temperature");

   // A shorted sensor always reports absolute zero.
   a_short_min: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[17:16] == ntcbc_pkg::STATUS_SHORTED)
      |-> (rsp_tdata[15:0] == ntcbc_pkg::TEMP_MIN))
      else $error("shorted-sensor reading not at absolute zero");

   // A new reading never appears straight after a request was taken.
   a_out_gap: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!(req_tvalid && req_tready)))
      else $error("reading appeared while a request was being taken");

endmodule

bind ntc_beta_temperature_converter ntcbc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/ntc_reading_checker.sv */
// Checker that predicts NTC temperature readings and compares them with the response channel.
`timescale 1ns / 1ps
module ntc_reading_checker
   import ntcbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output int          error_count,
   output int          readings_pending
);

   typedef struct {
      logic signed [15:0] temperature;
      logic [1:0]         status;
   } reading_t;

   localparam int SET_SIZE = 20;

   reading_t           readings_due[$];
   logic [23:0]        series_ohms, nominal_ohms;
   logic [13:0]        beta_value;
   logic signed [14:0] nominal_temp;
   logic [16:0]        therm_total, ref_total;
   int                 pairs_taken;

   assign readings_pending = readings_due.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Base-two logarithm in Q16, fraction truncated after sixteen squarings.
   function automatic longint log2_q16(input logic [63:0] x);
      int          p;
      logic [63:0] m;
      longint      frac;
      p = 63;
      frac = 0;
      while (p > 0 && !x[p]) p--;
      m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return longint'(p) * 65536 + frac;
   endfunction

   function automatic reading_t convert(input longint st, input longint sr);
      reading_t r;
      longint   diff, mag, lq, n, d, num, q, t;
      if (sr <= st) begin
         r.temperature = 0; r.status = STATUS_RATIO; return r;
      end
      if (st == 0 || series_ohms == 0) begin
         r.temperature = TEMP_MIN; r.status = STATUS_SHORTED; return r;
      end
      if (nominal_ohms == 0) begin
         r.temperature = TEMP_MIN; r.status = STATUS_SAT; return r;
      end
      diff = log2_q16(64'(series_ohms) * 64'(st)) - log2_q16(64'(sr - st) * 64'(nominal_ohms));
      mag = diff < 0 ? -diff : diff;
      mag = (mag * LN2_Q16 + 32768) >>> 16;
      lq = diff < 0 ? -mag : mag;
      n = longint'(nominal_temp) + KELVIN_OFFSET;
      d = lq * n + longint'(beta_value) * 6553600;
      if (d <= 0) begin
         r.temperature = TEMP_MAX; r.status = STATUS_SAT; return r;
      end
      num = 100 * longint'(beta_value) * n * 65536;
      q = (num + d / 2) / d;
      t = q - KELVIN_OFFSET;
      if (t > TEMP_MAX) begin
         r.temperature = TEMP_MAX; r.status = STATUS_SAT; return r;
      end
      if (t < TEMP_MIN) t = TEMP_MIN;
      r.temperature = 16'(t);
      r.status = STATUS_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      reading_t want;
      if (reset) begin
         series_ohms <= 24'd100000;
         nominal_ohms <= 24'd100000;
         beta_value <= 14'd3950;
         nominal_temp <= 15'sd2500;
         therm_total <= '0;
         ref_total <= '0;
         pairs_taken <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_SERIES:  series_ohms <= csr_wdata;
               REG_NOMINAL: nominal_ohms <= csr_wdata;
               REG_BETA:    beta_value <= csr_wdata[13:0];
               REG_NTEMP:   nominal_temp <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (pairs_taken == SET_SIZE - 1) begin
               readings_due.push_back(convert(therm_total + req_tdata[11:0],
                                              ref_total + req_tdata[23:12]));
               therm_total <= '0;
               ref_total <= '0;
               pairs_taken <= 0;
            end else begin
               therm_total <= therm_total + req_tdata[11:0];
               ref_total <= ref_total + req_tdata[23:12];
               pairs_taken <= pairs_taken + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (readings_due.size() == 0) begin
               report("unexpected reading", rsp_tdata[15:0], 0);
            end else begin
               want = readings_due.pop_front();
               if (rsp_tdata[15:0] !== want.temperature)
                  report("temperature", $signed(rsp_tdata[15:0]), want.temperature);
               if (rsp_tdata[17:16] !== want.status)
                  report("status", rsp_tdata[17:16], want.status);
               if (rsp_tdata[23:18] !== '0)
                  report("padding", rsp_tdata[23:18], 0);
            end
         end
      end
   end

   initial error_count = 0;

endmodule

/* bench/tb.sv */
// Stimulus and verdict for the NTC beta-equation temperature converter.
`timescale 1ns / 1ps
module tb;
   import ntcbc_pkg::*;

   localparam int SET_SIZE = 20;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = REG_SERIES;
   logic [23:0] csr_wdata = '0;
   int          error_count, readings_pending;
   longint      cycle_count = 0;
   bit          hold_off = 1'b0;
   int          stall_mode = 0;

   ntc_beta_temperature_converter u_top (.*);

   ntc_reading_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver back-pressure: a long hold-off when asked, else a shifting random pattern.
   always @(posedge clock) begin
      if (hold_off)
         rsp_tready <= 1'b0;
      else case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
   end

   // The request stays offered after it is taken; whoever stops sending drops it.
   task automatic send_pair(input logic [11:0] therm, input logic [11:0] refv);
      req_tvalid <= 1'b1;
      req_tdata <= {refv, therm};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (readings_pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // A whole set of one kind: fully random, near a chosen ratio with random spread, or near the extremes.
   task automatic send_set(input int kind);
      int base_t, base_r, t, r;
      base_t = $urandom_range(1, 4095);
      base_r = $urandom_range(base_t, 4095);
      for (int i = 0; i < SET_SIZE; i++) begin
         case (kind)
            0: begin t = $urandom_range(0, 4095); r = $urandom_range(0, 4095); end
            1: begin
               t = base_t + $urandom_range(0, 40) - 20;
               r = base_r + $urandom_range(0, 40) - 20;
               if (t < 0) t = 0; if (t > 4095) t = 4095;
               if (r < 0) r = 0; if (r > 4095) r = 4095;
            end
            2: begin t = $urandom_range(0, 3); r = $urandom_range(3000, 4095); end
            default: begin t = $urandom_range(3900, 4095); r = 4095; end
         endcase
         if ($urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         send_pair(t[11:0], r[11:0]);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int which);
      case (which)
         0: begin
            write_reg(REG_SERIES, 24'd100000); write_reg(REG_NOMINAL, 24'd100000);
            write_reg(REG_BETA, 24'd3950); write_reg(REG_NTEMP, 24'd2500);
         end
         1: begin
            write_reg(REG_SERIES, 24'd1); write_reg(REG_NOMINAL, 24'd10000000);
            write_reg(REG_BETA, 24'd1); write_reg(REG_NTEMP, 24'(-5000) & 24'h7fff);
         end
         2: begin
            write_reg(REG_SERIES, 24'd10000000); write_reg(REG_NOMINAL, 24'd1);
            write_reg(REG_BETA, 24'd10000); write_reg(REG_NTEMP, 24'd15000);
         end
         3: begin
            write_reg(REG_SERIES, 24'($urandom_range(1000, 10000000)));
            write_reg(REG_NOMINAL, 24'($urandom_range(1000, 10000000)));
            write_reg(REG_BETA, 24'($urandom_range(1000, 10000)));
            write_reg(REG_NTEMP, 24'($urandom_range(0, 20000) - 5000) & 24'h7fff);
         end
         default: begin
            write_reg(REG_SERIES, 24'hffffff); write_reg(REG_NOMINAL, 24'd0);
            write_reg(REG_BETA, 24'h3fff); write_reg(REG_NTEMP, 24'h4000);
         end
      endcase
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of the samples, the ratio fault, the shorted sensor, zero nominal resistance and zero beta.
      for (int i = 0; i < SET_SIZE; i++) send_pair(12'hfff, 12'h000);
      drain();
      write_reg(REG_SERIES, 24'd0);
      for (int i = 0; i < SET_SIZE; i++) send_pair(12'h000 + i, 12'hfff);
      drain();
      set_config(4);
      send_set(1);
      drain();
      write_reg(REG_NOMINAL, 24'd5);
      write_reg(REG_BETA, 24'd0);
      send_set(1);
      drain();

      // Long response hold-off while the sender keeps offering pairs.
      set_config(0);
      hold_off = 1'b1;
      fork
         begin
            for (int s = 0; s < 3; s++) send_set(0);
         end
         begin
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      drain();

      // Random phases, cycling through the register settings.
      for (int phase = 0; phase < 7; phase++) begin
         set_config(phase % 4);
         for (int s = 0; s < 5; s++) begin
            send_set($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, 60)) @(posedge clock);
         end
         drain();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
